/* design/rbox_pkg.sv */
// ----------------------------------------------------------------------------
// rbox_pkg
// Shared types and constants for the ray versus axis-aligned box slab test:
// request and response payloads, register indexes and pipeline depth.
// ----------------------------------------------------------------------------
package rbox_pkg;

   // Coordinate width of every Q-format field
   localparam int COORD_W = 32;

   // Register index port width and register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z = 3'd5;

   // Cycles from an accepted request to its response strobe
   localparam int PIPE_LAT = 8;

   // One ray
   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic signed [COORD_W-1:0] inv_dir_x;
      logic signed [COORD_W-1:0] inv_dir_y;
      logic signed [COORD_W-1:0] inv_dir_z;
      logic        [2:0]         sign_bits;
   } req_type;

   // One test result
   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } rsp_type;

endpackage

/* design/rbox_point.sv */
// ----------------------------------------------------------------------------
// rbox_point
// One coordinate of the hit point: origin + floor(dir * t / 2^FRAC_BITS),
// saturated to signed 32 bits. Two register stages, result combinational
// from the second.
// ----------------------------------------------------------------------------
module rbox_point
   import rbox_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic signed [COORD_W-1:0]   org,
   input  logic signed [COORD_W-1:0]   dir,
   input  logic        [63-FRAC_BITS:0] t_hit,
   output logic signed [COORD_W-1:0]   point
);

   localparam int TM_W   = 64 - FRAC_BITS;
   localparam int TH_W   = TM_W - COORD_W;
   localparam int PLO_W  = 2 * COORD_W + 1;
   localparam int PHI_W  = COORD_W + TH_W + 1;
   localparam int FULL_W = COORD_W + TM_W + 1;
   localparam int OFF_W  = FULL_W - FRAC_BITS;
   localparam int SUM_W  = OFF_W + 1;

   logic signed [PLO_W-1:0]   p_lo_in, p_lo_ff;
   logic signed [PHI_W-1:0]   p_hi_in, p_hi_ff;
   logic signed [COORD_W-1:0] org1_ff, org2_ff;
   logic signed [FULL_W-1:0]  full_in, full_ff;
   logic signed [OFF_W-1:0]   off;
   logic signed [SUM_W-1:0]   sum;
   logic                      fits;

   // Split the distance into a low word and a high part
   always_comb begin
      p_lo_in = PLO_W'(dir) * PLO_W'($signed({1'b0, t_hit[COORD_W-1:0]}));
      p_hi_in = PHI_W'(dir) * PHI_W'($signed({1'b0, t_hit[TM_W-1:COORD_W]}));
   end

   // Recombine the partial products
   always_comb begin
      full_in = (FULL_W'(p_hi_ff) <<< COORD_W) + FULL_W'(p_lo_ff);
   end

   always_ff @(posedge clock) begin
      p_lo_ff <= p_lo_in;
      p_hi_ff <= p_hi_in;
      org1_ff <= org;
      full_ff <= full_in;
      org2_ff <= org1_ff;
   end

   // Floor-scale, add origin, clamp to the signed word range
   always_comb begin
      off  = full_ff[FULL_W-1:FRAC_BITS];
      sum  = SUM_W'(off) + SUM_W'(org2_ff);
      fits = (&sum[SUM_W-1:COORD_W-1]) || !(|sum[SUM_W-1:COORD_W-1]);
      if (fits) begin
         point = sum[COORD_W-1:0];
      end else if (sum[SUM_W-1]) begin
         point = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         point = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

endmodule

/* design/ray_box_slab_intersect.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// An accepted request (start high, busy low) passes stages a to g and the
// output register to the rsp_valid strobe. Throughput: one ray per cycle
// while busy is low (high only around reset); the slab distance multipliers,
// interval narrowing and the point multipliers are each their own stages.
// Reset (synchronous, active high) empties the pipeline and clears the box.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect
   import rbox_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = DIFF_W + COORD_W;
   localparam int T_W    = PROD_W - FRAC_BITS;
   localparam int TM_W   = T_W - 1;

   logic busy_ff;
   logic accept;

   logic signed [COORD_W-1:0] box_min_ff [3];
   logic signed [COORD_W-1:0] box_max_ff [3];

   logic signed [COORD_W-1:0] org_in [3];
   logic signed [COORD_W-1:0] dir_in [3];
   logic signed [COORD_W-1:0] inv_in [3];
   logic signed [COORD_W-1:0] enter  [3];
   logic signed [COORD_W-1:0] leave  [3];

   // stage a: slab differences
   logic                      a_vld_ff;
   logic signed [DIFF_W-1:0]  a_den_in [3], a_den_ff [3];
   logic signed [DIFF_W-1:0]  a_dlv_in [3], a_dlv_ff [3];
   logic signed [COORD_W-1:0] a_inv_ff [3];
   logic signed [COORD_W-1:0] a_org_ff [3], a_dir_ff [3];

   // stage b: slab distances
   logic                      b_vld_ff;
   logic signed [PROD_W-1:0]  prod_en [3], prod_lv [3];
   logic signed [T_W-1:0]     b_ten_ff [3], b_tlv_ff [3];
   logic signed [COORD_W-1:0] b_org_ff [3], b_dir_ff [3];

   // stage c: narrow by y
   logic                      c_vld_ff, c_miss_in, c_miss_ff;
   logic signed [T_W-1:0]     c_tmin_in, c_tmin_ff, c_tmax_in, c_tmax_ff;
   logic signed [T_W-1:0]     c_tenz_ff, c_tlvz_ff;
   logic signed [COORD_W-1:0] c_org_ff [3], c_dir_ff [3];

   // stage d: narrow by z
   logic                      d_vld_ff, d_miss_in, d_miss_ff;
   logic signed [T_W-1:0]     d_tmin_in, d_tmin_ff, d_tmax_in, d_tmax_ff;
   logic signed [COORD_W-1:0] d_org_ff [3], d_dir_ff [3];

   // stage e: order interval, pick distance
   logic                      e_vld_ff, e_hit_in, e_hit_ff;
   logic signed [T_W-1:0]     lo_t, hi_t;
   logic        [TM_W-1:0]    e_t_in, e_t_ff;
   logic signed [COORD_W-1:0] e_org_ff [3], e_dir_ff [3];

   // stages f, g: inside the point units
   logic                      f_vld_ff, f_hit_ff, g_vld_ff, g_hit_ff;
   logic signed [COORD_W-1:0] pt [3];

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Hold off requests through reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Box corner registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_wdata;
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_wdata;
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_wdata;
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_wdata;
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_wdata;
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the ray and pick entry and exit corners
   always_comb begin
      org_in[0] = req_data.origin_x;
      org_in[1] = req_data.origin_y;
      org_in[2] = req_data.origin_z;
      dir_in[0] = req_data.dir_x;
      dir_in[1] = req_data.dir_y;
      dir_in[2] = req_data.dir_z;
      inv_in[0] = req_data.inv_dir_x;
      inv_in[1] = req_data.inv_dir_y;
      inv_in[2] = req_data.inv_dir_z;
      for (int ax = 0; ax < 3; ax++) begin
         enter[ax]    = req_data.sign_bits[ax] ? box_max_ff[ax] : box_min_ff[ax];
         leave[ax]    = req_data.sign_bits[ax] ? box_min_ff[ax] : box_max_ff[ax];
         a_den_in[ax] = DIFF_W'(enter[ax]) - DIFF_W'(org_in[ax]);
         a_dlv_in[ax] = DIFF_W'(leave[ax]) - DIFF_W'(org_in[ax]);
      end
   end

   // Slab distances: full product, floor by the fraction bits
   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         prod_en[ax] = PROD_W'(a_den_ff[ax]) * PROD_W'(a_inv_ff[ax]);
         prod_lv[ax] = PROD_W'(a_dlv_ff[ax]) * PROD_W'(a_inv_ff[ax]);
      end
   end

   // Narrow the x interval by the y slab
   always_comb begin
      c_miss_in = (b_ten_ff[0] > b_tlv_ff[1]) || (b_ten_ff[1] > b_tlv_ff[0]);
      c_tmin_in = (b_ten_ff[1] > b_ten_ff[0]) ? b_ten_ff[1] : b_ten_ff[0];
      c_tmax_in = (b_tlv_ff[1] < b_tlv_ff[0]) ? b_tlv_ff[1] : b_tlv_ff[0];
   end

   // Narrow by the z slab
   always_comb begin
      d_miss_in = c_miss_ff || (c_tmin_ff > c_tlvz_ff) || (c_tenz_ff > c_tmax_ff);
      d_tmin_in = (c_tenz_ff > c_tmin_ff) ? c_tenz_ff : c_tmin_ff;
      d_tmax_in = (c_tlvz_ff < c_tmax_ff) ? c_tlvz_ff : c_tmax_ff;
   end

   // Order the interval and take the nearest distance ahead of the origin
   always_comb begin
      if (d_tmin_ff > d_tmax_ff) begin
         lo_t = d_tmax_ff;
         hi_t = d_tmin_ff;
      end else begin
         lo_t = d_tmin_ff;
         hi_t = d_tmax_ff;
      end
      e_hit_in = !d_miss_ff && (!lo_t[T_W-1] || !hi_t[T_W-1]);
      e_t_in   = !lo_t[T_W-1] ? lo_t[TM_W-1:0] : hi_t[TM_W-1:0];
   end

   // Advance the datapath every cycle
   always_ff @(posedge clock) begin
      for (int ax = 0; ax < 3; ax++) begin
         a_den_ff[ax] <= a_den_in[ax];
         a_dlv_ff[ax] <= a_dlv_in[ax];
         a_inv_ff[ax] <= inv_in[ax];
         a_org_ff[ax] <= org_in[ax];
         a_dir_ff[ax] <= dir_in[ax];
         b_ten_ff[ax] <= prod_en[ax][PROD_W-1:FRAC_BITS];
         b_tlv_ff[ax] <= prod_lv[ax][PROD_W-1:FRAC_BITS];
         b_org_ff[ax] <= a_org_ff[ax];
         b_dir_ff[ax] <= a_dir_ff[ax];
         c_org_ff[ax] <= b_org_ff[ax];
         c_dir_ff[ax] <= b_dir_ff[ax];
         d_org_ff[ax] <= c_org_ff[ax];
         d_dir_ff[ax] <= c_dir_ff[ax];
         e_org_ff[ax] <= d_org_ff[ax];
         e_dir_ff[ax] <= d_dir_ff[ax];
      end
      c_miss_ff <= c_miss_in;
      c_tmin_ff <= c_tmin_in;
      c_tmax_ff <= c_tmax_in;
      c_tenz_ff <= b_ten_ff[2];
      c_tlvz_ff <= b_tlv_ff[2];
      d_miss_ff <= d_miss_in;
      d_tmin_ff <= d_tmin_in;
      d_tmax_ff <= d_tmax_in;
      e_hit_ff  <= e_hit_in;
      e_t_ff    <= e_t_in;
      f_hit_ff  <= e_hit_ff;
      g_hit_ff  <= f_hit_ff;
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         f_vld_ff     <= 1'b0;
         g_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff     <= accept;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         e_vld_ff     <= d_vld_ff;
         f_vld_ff     <= e_vld_ff;
         g_vld_ff     <= f_vld_ff;
         rsp_valid_ff <= g_vld_ff;
      end
   end

   // Hit point, one unit per axis
   for (genvar ax = 0; ax < 3; ax++) begin : g_point
      rbox_point #(
         .FRAC_BITS (FRAC_BITS)
      ) u_point (
         .clock (clock),
         .org   (e_org_ff[ax]),
         .dir   (e_dir_ff[ax]),
         .t_hit (e_t_ff),
         .point (pt[ax])
      );
   end

   // Output register; zero the point on a miss
   always_ff @(posedge clock) begin
      rsp_data_ff.hit     <= g_hit_ff;
      rsp_data_ff.point_x <= g_hit_ff ? pt[0] : '0;
      rsp_data_ff.point_y <= g_hit_ff ? pt[1] : '0;
      rsp_data_ff.point_z <= g_hit_ff ? pt[2] : '0;
   end

endmodule

/* design/rbox_checker.sv */
// ----------------------------------------------------------------------------
// rbox_checker
// Port-level checks of the slab test: fixed response latency, one response
// per request, zero point on a miss, busy only around reset.
// ----------------------------------------------------------------------------
module rbox_checker
   import rbox_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Every transfer in gets its response a fixed time later
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_valid)
      else $error("response missing after accepted request");

   // No response without a request at the matching time
   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LAT))
      else $error("response without matching request");

   // A miss carries a zero point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.point_x == '0 && rsp_data.point_y == '0 && rsp_data.point_z == '0))
      else $error("miss with nonzero point");

   // Busy clears once reset is gone
   a_busy_reset: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy outside reset");

endmodule

bind ray_box_slab_intersect rbox_checker u_rbox_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
